// ===== hdl/igf_pkg.sv =====
// ----------------------------------------------------------------------------
// igf_pkg
// Shared types and constants for the interval guard feasibility block.
// ----------------------------------------------------------------------------
package igf_pkg;

	// Capacity of the site store and derived widths
	localparam int MAX_SITES = 256;
	localparam int SITE_AW   = $clog2(MAX_SITES);
	localparam int CNT_W     = $clog2(MAX_SITES + 1);
	localparam int DAY_W     = 15;
	localparam int GC_W      = 16;
	localparam int SITE_W    = 2 * DAY_W;

	// One stored interval, start day in the low bits
	typedef struct packed {
		logic [DAY_W-1:0] end_day;
		logic [DAY_W-1:0] start_day;
	} site_t;

	// Memory requests from the sequencer
	typedef struct packed {
		logic               site_we;
		logic [SITE_AW-1:0] site_waddr;
		site_t              site_wdata;
		logic [SITE_AW-1:0] site_raddr;
		logic               grd_we;
		logic [SITE_AW-1:0] grd_waddr;
		logic [DAY_W-1:0]   grd_wdata;
		logic [SITE_AW-1:0] grd_raddr;
	} mem_req_t;

	// Decision handed to the output register
	typedef struct packed {
		logic valid;
		logic feasible;
		logic overflow;
	} res_t;

	// Sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_SORT_KEY_RD,
		ST_SORT_KEY_LD,
		ST_SORT_RD,
		ST_SORT_CMP,
		ST_WALK_SITE_RD,
		ST_WALK_SITE_LD,
		ST_WALK_G_RD,
		ST_WALK_G_CMP,
		ST_DONE
	} state_t;

endpackage

// ===== hdl/igf_ram.sv =====
// ----------------------------------------------------------------------------
// igf_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module igf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hdl/igf_ctrl.sv =====
// ----------------------------------------------------------------------------
// igf_ctrl
// Load sequencer, insertion sort over the site RAM and first-fit guard walk.
// ----------------------------------------------------------------------------
module igf_ctrl (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [igf_pkg::GC_W-1:0] guard_count,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     in_carries,
	input  logic [igf_pkg::DAY_W-1:0] in_start,
	input  logic [igf_pkg::DAY_W-1:0] in_end,
	input  logic                     in_last,
	input  logic                     res_ready,
	output igf_pkg::res_t            res,
	output igf_pkg::mem_req_t        req,
	input  igf_pkg::site_t           site_rdata,
	input  logic [igf_pkg::DAY_W-1:0] grd_rdata
);
	import igf_pkg::*;

	state_t            state_q, state_d;
	logic [CNT_W-1:0]  total_q;
	logic              ovf_q;
	logic [CNT_W-1:0]  i_q;
	logic [CNT_W-1:0]  j_q;
	logic [CNT_W-1:0]  g_q;
	logic [CNT_W-1:0]  used_q;
	logic              result_q;
	site_t             key_q;
	logic [DAY_W-1:0]  cur_start_q;
	logic [DAY_W-1:0]  cur_end_q;

	logic              in_acc;
	logic              room;
	logic              trivial;
	logic              trivial_ok;
	logic              key_before;
	logic [DAY_W-1:0]  guard_end;
	logic              guard_busy;
	logic [CNT_W-1:0]  g_inc;
	logic              guards_out;
	logic [CNT_W-1:0]  j_dec;

	assign in_acc = in_valid && in_ready;
	assign room   = (total_q < CNT_W'(MAX_SITES));

	// shortcut decisions that need no walk
	assign trivial    = (total_q == '0) || (guard_count == '0) ||
	                    (guard_count > GC_W'(total_q));
	assign trivial_ok = (total_q == '0) || (guard_count != '0);

	// sort order: start day, then end day
	assign key_before = (key_q.start_day < site_rdata.start_day) ||
	                    ((key_q.start_day == site_rdata.start_day) &&
	                     (key_q.end_day < site_rdata.end_day));

	// guards at or above the fill count are still free (last end zero)
	assign guard_end  = (g_q < used_q) ? grd_rdata : '0;
	assign guard_busy = (guard_end >= cur_start_q);
	assign g_inc      = g_q + CNT_W'(1);
	assign guards_out = (GC_W'(g_inc) == guard_count);
	assign j_dec      = j_q - CNT_W'(1);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc && in_last) state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				state_d = trivial ? ST_DONE : ST_SORT_KEY_RD;
			end
			ST_SORT_KEY_RD: begin
				state_d = (i_q >= total_q) ? ST_WALK_SITE_RD : ST_SORT_KEY_LD;
			end
			ST_SORT_KEY_LD: begin
				state_d = ST_SORT_RD;
			end
			ST_SORT_RD: begin
				state_d = (j_q == '0) ? ST_SORT_KEY_RD : ST_SORT_CMP;
			end
			ST_SORT_CMP: begin
				state_d = key_before ? ST_SORT_RD : ST_SORT_KEY_RD;
			end
			ST_WALK_SITE_RD: begin
				state_d = (i_q == total_q) ? ST_DONE : ST_WALK_SITE_LD;
			end
			ST_WALK_SITE_LD: begin
				state_d = ST_WALK_G_RD;
			end
			ST_WALK_G_RD: begin
				state_d = ST_WALK_G_CMP;
			end
			ST_WALK_G_CMP: begin
				if (guard_busy) begin
					state_d = guards_out ? ST_DONE : ST_WALK_G_RD;
				end else begin
					state_d = ST_WALK_SITE_RD;
				end
			end
			ST_DONE: begin
				if (res_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs: handshake, result and memory requests
	always_comb begin
		in_ready     = 1'b0;
		res.valid    = 1'b0;
		res.feasible = result_q;
		res.overflow = ovf_q;
		req          = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready                 = 1'b1;
				req.site_we              = in_acc && in_carries && room;
				req.site_waddr           = total_q[SITE_AW-1:0];
				req.site_wdata.start_day = in_start;
				req.site_wdata.end_day   = in_end;
			end
			ST_SORT_KEY_RD: begin
				req.site_raddr = i_q[SITE_AW-1:0];
			end
			ST_SORT_RD: begin
				req.site_raddr = j_dec[SITE_AW-1:0];
				req.site_we    = (j_q == '0);
				req.site_waddr = '0;
				req.site_wdata = key_q;
			end
			ST_SORT_CMP: begin
				req.site_we    = 1'b1;
				req.site_waddr = j_q[SITE_AW-1:0];
				req.site_wdata = key_before ? site_rdata : key_q;
			end
			ST_WALK_SITE_RD: begin
				req.site_raddr = i_q[SITE_AW-1:0];
			end
			ST_WALK_G_RD: begin
				req.grd_raddr = g_q[SITE_AW-1:0];
			end
			ST_WALK_G_CMP: begin
				req.grd_we    = !guard_busy;
				req.grd_waddr = g_q[SITE_AW-1:0];
				req.grd_wdata = cur_end_q;
			end
			ST_DONE: begin
				res.valid = 1'b1;
			end
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			total_q  <= '0;
			ovf_q    <= 1'b0;
			i_q      <= '0;
			j_q      <= '0;
			g_q      <= '0;
			used_q   <= '0;
			result_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					if (in_acc && in_carries) begin
						if (room) total_q <= total_q + CNT_W'(1);
						else      ovf_q   <= 1'b1;
					end
				end
				ST_DECIDE: begin
					result_q <= trivial_ok;
					i_q      <= CNT_W'(1);
				end
				ST_SORT_KEY_RD: begin
					if (i_q >= total_q) begin
						i_q    <= '0;
						used_q <= '0;
					end
				end
				ST_SORT_KEY_LD: begin
					j_q <= i_q;
				end
				ST_SORT_RD: begin
					if (j_q == '0) i_q <= i_q + CNT_W'(1);
				end
				ST_SORT_CMP: begin
					if (key_before) j_q <= j_dec;
					else            i_q <= i_q + CNT_W'(1);
				end
				ST_WALK_SITE_RD: begin
					if (i_q == total_q) result_q <= 1'b1;
				end
				ST_WALK_SITE_LD: begin
					g_q <= '0;
				end
				ST_WALK_G_CMP: begin
					if (guard_busy) begin
						g_q <= g_inc;
						if (guards_out) result_q <= 1'b0;
					end else begin
						if (g_q == used_q) used_q <= used_q + CNT_W'(1);
						i_q <= i_q + CNT_W'(1);
					end
				end
				ST_DONE: begin
					if (res_ready) begin
						total_q <= '0;
						ovf_q   <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_SORT_KEY_LD) begin
			key_q <= site_rdata;
		end
		if (state_q == ST_WALK_SITE_LD) begin
			cur_start_q <= site_rdata.start_day;
			cur_end_q   <= site_rdata.end_day;
		end
	end

endmodule

// ===== hdl/interval_guard_feasibility.sv =====
// Beats are accepted one per cycle while intake is open; a tlast beat closes
// intake until the decision is handed to the output register. The decision runs
// an insertion sort and then a first-fit walk, both bound by the single read
// port of the site and guard RAMs.
// Trivial sets (no sites, no guards, more guards than sites) skip sort and walk.
// Reset (arst_n low, asynchronous) empties the set and sets guard_count to 0.
// ----------------------------------------------------------------------------
// interval_guard_feasibility
// Collects duty intervals and decides whether guard_count guards cover them.
// ----------------------------------------------------------------------------
module interval_guard_feasibility (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_wen,
	input  logic [igf_pkg::GC_W-1:0] cfg_wdata,
	input  logic                     s_axis_tvalid,
	output logic                     s_axis_tready,
	input  logic [31:0]              s_axis_tdata,  // start_day[14:0], end_day[29:15]
	input  logic [0:0]               s_axis_tuser,  // carries_site[0]
	input  logic                     s_axis_tlast,
	output logic                     m_axis_tvalid,
	input  logic                     m_axis_tready,
	output logic [7:0]               m_axis_tdata   // feasible[0], overflow[1]
);
	import igf_pkg::*;

	logic [GC_W-1:0]  guard_count_q;
	logic             out_valid_q;
	logic [1:0]       out_data_q;
	logic             res_ready;
	res_t             res;
	mem_req_t         req;
	site_t            site_rdata;
	logic [DAY_W-1:0] grd_rdata;
	logic [SITE_W-1:0] site_rword;

	// guard count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			guard_count_q <= '0;
		end else if (cfg_wen) begin
			guard_count_q <= cfg_wdata;
		end
	end

	igf_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.guard_count (guard_count_q),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.in_carries  (s_axis_tuser[0]),
		.in_start    (s_axis_tdata[DAY_W-1:0]),
		.in_end      (s_axis_tdata[2*DAY_W-1:DAY_W]),
		.in_last     (s_axis_tlast),
		.res_ready   (res_ready),
		.res         (res),
		.req         (req),
		.site_rdata  (site_rdata),
		.grd_rdata   (grd_rdata)
	);

	// site store
	igf_ram #(.WIDTH(SITE_W), .DEPTH(MAX_SITES)) u_site_ram (
		.clk   (clk),
		.we    (req.site_we),
		.waddr (req.site_waddr),
		.wdata (req.site_wdata),
		.raddr (req.site_raddr),
		.rdata (site_rword)
	);
	assign site_rdata = site_t'(site_rword);

	// last end day per guard
	igf_ram #(.WIDTH(DAY_W), .DEPTH(MAX_SITES)) u_guard_ram (
		.clk   (clk),
		.we    (req.grd_we),
		.waddr (req.grd_waddr),
		.wdata (req.grd_wdata),
		.raddr (req.grd_raddr),
		.rdata (grd_rdata)
	);

	// output register
	assign res_ready = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid && res_ready) begin
			out_data_q <= {res.overflow, res.feasible};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'd0, out_data_q};

	// a closing beat stops intake until the decision is out
	a_last_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
		else $error("input still open after closing beat");

	// site writes while intake is open come only from accepted site beats
	a_site_wr_src: assert property (@(posedge clk) disable iff (!arst_n)
		req.site_we && s_axis_tready |-> s_axis_tvalid && s_axis_tuser[0])
		else $error("site write without an accepted site beat");

	// guard RAM is touched only during the walk
	a_guard_wr_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req.grd_we |-> !s_axis_tready)
		else $error("guard write while intake is open");

	// a new result follows a cycle with intake closed
	a_result_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(!s_axis_tready))
		else $error("result appeared without a decision phase");

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stream-level test of interval_guard_feasibility. Interval beats are fed from
// a queue, and each closing beat is scored against a software first-fit
// partitioning of the collected set. Guard counts change between phases, and
// both stream sides stall at random.
// ----------------------------------------------------------------------------
module tb;
	import igf_pkg::*;

	localparam int CYCLE_LIMIT = 3000000;
	localparam int RANDOM_ITEMS = 1900;

	// One input beat as the block sees it
	typedef struct {
		bit             carries;
		bit [DAY_W-1:0] start_day;
		bit [DAY_W-1:0] end_day;
		bit             last;
	} site_beat_t;

	// One decision as the block should report it
	typedef struct {
		bit feasible;
		bit overflow;
	} verdict_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_wen = 1'b0;
	logic [GC_W-1:0]  cfg_wdata = '0;
	logic             s_axis_tvalid = 1'b0;
	logic             s_axis_tready;
	logic [31:0]      s_axis_tdata = '0;  // start_day[14:0], end_day[29:15]
	logic [0:0]       s_axis_tuser = '0;  // carries_site[0]
	logic             s_axis_tlast = 1'b0;
	logic             m_axis_tvalid;
	logic             m_axis_tready = 1'b0;
	logic [7:0]       m_axis_tdata;       // feasible[0], overflow[1]

	// Stimulus and expectation stores
	site_beat_t       beat_q[$];
	site_beat_t       beat_on_bus;
	verdict_t         verdict_q[$];

	// Predictor state: the open set and the guard count in force
	bit [DAY_W-1:0]   open_starts[$];
	bit [DAY_W-1:0]   open_ends[$];
	bit               open_overflow = 1'b0;
	int               guard_cfg = 0;

	int               mismatch_count = 0;
	int               cycle_count = 0;
	int               items_sent = 0;
	int               src_gap = 0;
	int               snk_stall = 0;
	bit               src_steady = 1'b0;
	bit               snk_steady = 1'b0;

	interval_guard_feasibility i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wen       (cfg_wen),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Idle length: mostly none, some short, a few long
	function automatic int pick_gap(input bit steady);
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(6, 30);
	endfunction

	// Sort by start then end, then first-fit the intervals onto the guards
	function automatic bit guards_suffice(input bit [DAY_W-1:0] st[$],
			input bit [DAY_W-1:0] en[$], input int guards);
		bit [DAY_W-1:0] busy_until[$];
		bit [DAY_W-1:0] ts;
		bit [DAY_W-1:0] te;
		int n;
		int i;
		int j;
		int g;
		n = st.size();
		if (n == 0)
			return 1'b1;
		if (guards == 0)
			return 1'b0;
		if (guards > n)
			return 1'b1;
		for (i = 1; i < n; i++) begin
			j = i;
			while (j > 0 && (st[j] < st[j-1] || (st[j] == st[j-1] && en[j] < en[j-1]))) begin
				ts = st[j];
				te = en[j];
				st[j] = st[j-1];
				en[j] = en[j-1];
				st[j-1] = ts;
				en[j-1] = te;
				j--;
			end
		end
		for (g = 0; g < guards; g++)
			busy_until.push_back('0);
		for (i = 0; i < n; i++) begin
			g = 0;
			// a free guard holds 0, so a start day of 0 never fits
			while (g < guards && busy_until[g] >= st[i])
				g++;
			if (g == guards)
				return 1'b0;
			busy_until[g] = en[i];
		end
		return 1'b1;
	endfunction

	// Fold an accepted beat into the open set; a closing beat yields a verdict
	task automatic absorb_beat(input site_beat_t b);
		verdict_t v;
		if (b.carries) begin
			if (open_starts.size() < MAX_SITES) begin
				open_starts.push_back(b.start_day);
				open_ends.push_back(b.end_day);
			end else begin
				open_overflow = 1'b1;
			end
		end
		if (b.last) begin
			v.feasible = guards_suffice(open_starts, open_ends, guard_cfg);
			v.overflow = open_overflow;
			verdict_q.push_back(v);
			open_starts.delete();
			open_ends.delete();
			open_overflow = 1'b0;
		end
	endtask

	task automatic flag_mismatch(input string what);
		mismatch_count++;
		$display("[%0t] MISMATCH: %s", $realtime, what);
	endtask

	task automatic add_beat(input bit c, input int s, input int e, input bit l);
		site_beat_t b;
		b.carries = c;
		b.start_day = s[DAY_W-1:0];
		b.end_day = e[DAY_W-1:0];
		b.last = l;
		beat_q.push_back(b);
	endtask

	// Small set in a narrow day window so guards collide, with some noise
	task automatic queue_set(input int n);
		int w;
		int k;
		int r;
		int s;
		bit close_apart;
		w = $urandom_range(4, 80);
		close_apart = (n == 0) || ($urandom_range(0, 3) == 0);
		for (k = 0; k < n; k++) begin
			r = $urandom_range(0, 39);
			if (r == 0) begin
				add_beat(1'b1, 0, $urandom_range(0, 32767), 1'b0);
			end else if (r <= 3) begin
				// full-range days, end may fall before start
				add_beat(1'b1, $urandom_range(0, 32767), $urandom_range(0, 32767), 1'b0);
			end else begin
				s = $urandom_range(1, w);
				add_beat(1'b1, s, s + $urandom_range(0, w / 3), 1'b0);
			end
			if (k == n - 1 && !close_apart)
				beat_q[beat_q.size()-1].last = 1'b1;
			items_sent++;
			// ignored beat: no site, not closing
			if ($urandom_range(0, 9) == 0)
				add_beat(1'b0, $urandom_range(0, 32767), $urandom_range(0, 32767), 1'b0);
		end
		if (close_apart) begin
			add_beat(1'b0, $urandom_range(0, 32767), $urandom_range(0, 32767), 1'b1);
			items_sent++;
		end
	endtask

	// Large set of short intervals spread over a couple thousand days
	task automatic queue_crowd(input int n);
		int k;
		int s;
		for (k = 0; k < n; k++) begin
			s = $urandom_range(1, 2000);
			add_beat(1'b1, s, s + $urandom_range(0, 60), k == n - 1);
			items_sent++;
		end
	endtask

	// Block idle: all beats taken, all verdicts back, trailing beats retired
	task automatic settle();
		while (beat_q.size() != 0 || s_axis_tvalid || verdict_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic load_guards(input int v);
		@(posedge clk);
		cfg_wen <= 1'b1;
		cfg_wdata <= v[GC_W-1:0];
		@(posedge clk);
		cfg_wen <= 1'b0;
		guard_cfg = v & 16'hFFFF;
	endtask

	// Source side: present queued beats, hold while stalled, idle between beats
	always @(posedge clk or negedge arst_n) begin : feeder
		site_beat_t nxt;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tuser <= '0;
			s_axis_tlast <= 1'b0;
			src_gap <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				absorb_beat(beat_on_bus);
			if (!s_axis_tvalid || s_axis_tready) begin
				if (src_gap > 0) begin
					s_axis_tvalid <= 1'b0;
					src_gap <= src_gap - 1;
				end else if (beat_q.size() > 0) begin
					nxt = beat_q.pop_front();
					beat_on_bus <= nxt;
					s_axis_tdata <= {2'b00, nxt.end_day, nxt.start_day};
					s_axis_tuser <= nxt.carries;
					s_axis_tlast <= nxt.last;
					s_axis_tvalid <= 1'b1;
					src_gap <= pick_gap(src_steady);
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Sink side: score each verdict beat, stall at random
	always @(posedge clk or negedge arst_n) begin : sink
		verdict_t want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			snk_stall <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (verdict_q.size() == 0) begin
					flag_mismatch($sformatf("unexpected result beat, tdata %02h", m_axis_tdata));
				end else begin
					want = verdict_q.pop_front();
					if (m_axis_tdata[0] !== want.feasible)
						flag_mismatch($sformatf("feasible got %b want %b",
							m_axis_tdata[0], want.feasible));
					if (m_axis_tdata[1] !== want.overflow)
						flag_mismatch($sformatf("overflow got %b want %b",
							m_axis_tdata[1], want.overflow));
				end
			end
			if (snk_stall > 0) begin
				m_axis_tready <= 1'b0;
				snk_stall <= snk_stall - 1;
			end else begin
				m_axis_tready <= 1'b1;
				if (!snk_steady && $urandom_range(0, 5) == 0)
					snk_stall <= pick_gap(1'b0);
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin : stimulus
		int gc;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero guards after reset: empty set passes, one site fails
		add_beat(1'b0, 0, 0, 1'b1);
		add_beat(1'b1, 5, 9, 1'b1);
		settle();

		// one guard: ignored beat, day extremes, shared boundary day,
		// back-to-back days, start day zero, unsorted arrival
		load_guards(1);
		add_beat(1'b0, 7, 7, 1'b0);
		add_beat(1'b1, 1, 1, 1'b0);
		add_beat(1'b1, 32767, 32767, 1'b1);
		add_beat(1'b1, 10, 20, 1'b0);
		add_beat(1'b1, 20, 30, 1'b1);
		add_beat(1'b1, 10, 19, 1'b0);
		add_beat(1'b1, 20, 30, 1'b1);
		add_beat(1'b1, 0, 5, 1'b1);
		add_beat(1'b1, 30, 40, 1'b0);
		add_beat(1'b1, 5, 8, 1'b0);
		add_beat(1'b1, 9, 12, 1'b1);
		settle();

		// two guards: triple overlap closed by a siteless beat, tie on start,
		// end before start with more guards than sites
		load_guards(2);
		add_beat(1'b1, 1, 10, 1'b0);
		add_beat(1'b1, 2, 11, 1'b0);
		add_beat(1'b1, 3, 12, 1'b0);
		add_beat(1'b0, 0, 0, 1'b1);
		add_beat(1'b1, 1, 5, 1'b0);
		add_beat(1'b1, 1, 3, 1'b0);
		add_beat(1'b1, 4, 9, 1'b1);
		add_beat(1'b1, 100, 50, 1'b1);
		settle();

		// all guards
		load_guards(16'hFFFF);
		add_beat(1'b1, 1, 100, 1'b0);
		add_beat(1'b1, 1, 100, 1'b1);
		settle();

		// a full store and an overflowing one with a real walk
		load_guards($urandom_range(2, 12));
		queue_crowd(MAX_SITES);
		queue_crowd(MAX_SITES + 4);
		settle();
		load_guards(16'hFFFF);
		queue_crowd(MAX_SITES + 2);
		settle();

		// random phases of small sets under changing guard counts
		while (items_sent < RANDOM_ITEMS) begin
			case ($urandom_range(0, 9))
				0: gc = 0;
				1: gc = 16'hFFFF;
				2: gc = $urandom_range(0, 65535);
				default: gc = $urandom_range(1, 6);
			endcase
			src_steady = ($urandom_range(0, 3) == 0);
			snk_steady = ($urandom_range(0, 3) == 0);
			load_guards(gc);
			repeat ($urandom_range(4, 10)) queue_set($urandom_range(0, 12));
			settle();
		end

		repeat (40) @(posedge clk);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ===== files.f =====
hdl/igf_pkg.sv
hdl/igf_ram.sv
hdl/igf_ctrl.sv
hdl/interval_guard_feasibility.sv
dv/tb.sv
